// ===== rtl/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg: shared types and codes for the texture slice allocator
// Function codes, status codes and payload structs.
// ----------------------------------------------------------------------------
package tsa_pkg;
    localparam int W_DIM = 15;

    typedef enum logic [1:0] {
        FUNC_REGISTER  = 2'd0,
        FUNC_DEL_SLICE = 2'd1,
        FUNC_DEL_ARRAY = 2'd2,
        FUNC_UNUSED    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_IDX  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [W_DIM-1:0] img_width;
        logic [W_DIM-1:0] img_height;
        logic             want_render_target;
        logic             want_compressed;
        logic [4:0]       target_array;
        logic [5:0]       target_slice;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] got_array;
        logic [5:0] got_slice;
        logic       new_array;
        logic       array_freed;
    } rsp_t;
endpackage

// ===== rtl/tsa_stream_if.sv =====
// ----------------------------------------------------------------------------
// tsa_stream_if: valid/ready channel
// Carries one request or one response payload.
// ----------------------------------------------------------------------------
interface tsa_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tsa_table.sv =====
// ----------------------------------------------------------------------------
// tsa_table: array table memory
// One entry per array: count, key, flags, deleted map. Registered read.
// ----------------------------------------------------------------------------
module tsa_table #(
    parameter int ARRAYS = 32,
    parameter int AW = 5,
    parameter int EW = 64
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr,
    output logic [EW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data
);
    logic [EW-1:0] mem [ARRAYS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/texture_slice_allocator.sv =====
// ----------------------------------------------------------------------------
// texture_slice_allocator: texture array slice allocator
// Table of arrays keyed by size and kind, held in one memory.
// ----------------------------------------------------------------------------
// Register: scans used arrays for a match, then for an empty entry (one memory
//   read per cycle); delete slice trims the top; delete array writes on accept.
// Throughput: one request at a time; ready only while idle with no response pending.
// Reset: clears control and high-water count, then a clearing pass writes every
//   entry to zero; no request accepted meanwhile.
module texture_slice_allocator #(
    parameter int ARRAYS = 32,
    parameter int SLICES = 64
) (
    input logic clk,
    input logic rst_n,
    tsa_stream_if.sink   req,
    tsa_stream_if.source rsp
);
    import tsa_pkg::*;

    localparam int AW = (ARRAYS > 1) ? $clog2(ARRAYS) : 1;
    localparam int HW = $clog2(ARRAYS + 1);
    localparam int SW = $clog2(SLICES);
    localparam int CW = $clog2(SLICES + 1);
    // entry: map | flags(3) | h | w | count
    localparam int EW = SLICES + 3 + 2 * W_DIM + CW;
    localparam logic [2:0] FLAG_DEL = 3'b100;

    typedef struct packed {
        logic [SLICES-1:0] dmap;
        logic [2:0]        flags;
        logic [W_DIM-1:0]  h;
        logic [W_DIM-1:0]  w;
        logic [CW-1:0]     cnt;
    } entry_t;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SCAN1 = 9'b000000100,
        S_SCAN2 = 9'b000001000,
        S_DREAD = 9'b000010000,
        S_DEL   = 9'b000100000,
        S_TRIM  = 9'b001000000,
        S_OPEN  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [HW-1:0] hw_reg, hw_next;
    logic [HW-1:0] idx_reg, idx_next;   // address in flight (scan)
    req_t          q_reg, q_next;
    rsp_t          out_reg, out_next;
    logic          out_v_reg, out_v_next;
    entry_t        ent_reg, ent_next;    // working copy for trim

    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_raw;
    entry_t        rd_ent;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_ent;

    assign rd_ent = entry_t'(rd_raw);

    tsa_table #(.ARRAYS(ARRAYS), .AW(AW), .EW(EW)) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_raw),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (EW'(wr_ent))
    );

    assign req.ready = (state_reg == S_IDLE) && !out_v_reg;
    assign rsp.valid = out_v_reg;
    assign rsp.data  = out_reg;

    logic          match;
    logic [HW-1:0] idx_inc;
    logic [AW-1:0] ta;
    logic [SW-1:0] ts;
    logic [SW-1:0] top;

    assign ta      = AW'(q_reg.target_array);
    assign ts      = SW'(q_reg.target_slice);
    assign idx_inc = idx_reg + HW'(1);
    assign top     = SW'(ent_reg.cnt - CW'(1));
    assign match   = ((rd_ent.flags & FLAG_DEL) == 3'b000) && (rd_ent.cnt != '0)
                  && (rd_ent.w == q_reg.img_width) && (rd_ent.h == q_reg.img_height)
                  && (rd_ent.flags[1:0] == {q_reg.want_compressed,
                                            q_reg.want_render_target});

    always_comb
    begin
        state_next = state_reg;
        hw_next    = hw_reg;
        idx_next   = idx_reg;
        q_next     = q_reg;
        out_next   = out_reg;
        out_v_next = out_v_reg;
        ent_next   = ent_reg;
        rd_addr    = AW'(idx_reg);
        wr_en      = 1'b0;
        wr_addr    = AW'(idx_reg);
        wr_ent     = '0;
        if (rsp.valid && rsp.ready)
        begin
            out_v_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_inc;
                if (idx_reg == HW'(ARRAYS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    q_next   = req.data;
                    idx_next = '0;
                    out_next = '0;
                    rd_addr  = AW'(req.data.target_array);
                    priority case (func_t'(req.data.func))
                        FUNC_REGISTER:
                        begin
                            rd_addr    = '0;
                            state_next = S_SCAN1;
                        end
                        FUNC_DEL_SLICE:
                        begin
                            if (HW'(req.data.target_array) >= hw_reg
                                || 32'(req.data.target_array) >= ARRAYS)
                            begin
                                out_next.status = ST_BAD_IDX;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                state_next = S_DREAD;
                            end
                        end
                        FUNC_DEL_ARRAY:
                        begin
                            if (HW'(req.data.target_array) >= hw_reg
                                || 32'(req.data.target_array) >= ARRAYS)
                            begin
                                out_next.status = ST_BAD_IDX;
                            end
                            else
                            begin
                                out_next.status = ST_OK;
                                wr_en           = 1'b1;
                                wr_addr         = AW'(req.data.target_array);
                                wr_ent.flags    = FLAG_DEL;
                            end
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            out_next.status = ST_BAD_IDX;
                            state_next      = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN1:
            begin
                // rd_ent holds entry idx_reg; read of idx+1 issued now
                rd_addr = AW'(idx_inc);
                if (idx_reg >= hw_reg)
                begin
                    idx_next   = '0;
                    rd_addr    = '0;
                    state_next = S_SCAN2;
                end
                else if (match)
                begin
                    if (rd_ent.cnt >= CW'(SLICES))
                    begin
                        out_next.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en  = 1'b1;
                        wr_ent = rd_ent;
                        wr_ent.dmap[SW'(rd_ent.cnt)] = 1'b0;
                        wr_ent.cnt = rd_ent.cnt + CW'(1);
                        out_next.got_array = 5'(idx_reg);
                        out_next.got_slice = 6'(rd_ent.cnt);
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_SCAN2:
            begin
                rd_addr = AW'(idx_inc);
                if (idx_reg >= hw_reg)
                begin
                    if (hw_reg >= HW'(ARRAYS))
                    begin
                        out_next.status = ST_NO_FREE;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        hw_next    = hw_reg + HW'(1);
                        state_next = S_OPEN;
                    end
                end
                else if (rd_ent.cnt == '0)
                begin
                    state_next = S_OPEN;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_OPEN:
            begin
                wr_en        = 1'b1;
                wr_ent.cnt   = CW'(1);
                wr_ent.w     = q_reg.img_width;
                wr_ent.h     = q_reg.img_height;
                wr_ent.flags = {1'b0, q_reg.want_compressed, q_reg.want_render_target};
                out_next.got_array = 5'(idx_reg);
                out_next.new_array = 1'b1;
                state_next         = S_OUT;
            end
            S_DREAD:
            begin
                rd_addr    = ta;
                state_next = S_DEL;
            end
            S_DEL:
            begin
                rd_addr = ta;
                if (CW'(q_reg.target_slice) >= rd_ent.cnt
                    || q_reg.target_slice > 6'(SLICES - 1)
                    || rd_ent.dmap[ts])
                begin
                    out_next.status = ST_BAD_IDX;
                    state_next      = S_OUT;
                end
                else
                begin
                    ent_next           = rd_ent;
                    ent_next.dmap[ts]  = 1'b1;
                    state_next         = S_TRIM;
                end
            end
            S_TRIM:
            begin
                // one slice per cycle off the top
                if (ent_reg.cnt != '0 && ent_reg.dmap[top])
                begin
                    ent_next.cnt = ent_reg.cnt - CW'(1);
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = ta;
                    if (ent_reg.cnt == '0)
                    begin
                        wr_ent.flags         = FLAG_DEL;
                        out_next.array_freed = 1'b1;
                    end
                    else
                    begin
                        wr_ent = ent_reg;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_v_reg)
                begin
                    out_v_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            hw_reg    <= '0;
            idx_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hw_reg    <= hw_next;
            idx_reg   <= idx_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        out_reg <= out_next;
        ent_reg <= ent_next;
    end

    a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= HW'(ARRAYS)) else $error("high-water beyond table");
    a_hw_mono: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg >= $past(hw_reg)) else $error("high-water decreased");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg != S_IDLE)
        else $error("request accepted without work");
    a_new_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.new_array) |-> rsp.data.status == ST_OK)
        else $error("fresh array with error status");
endmodule
